@@ hw/rtl/fgb_pkg.sv @@
`timescale 1ns / 1ps

package fgb_pkg;

  localparam int unsigned FONT_BYTES      = 32768;
  localparam int unsigned FONT_AW         = $clog2(FONT_BYTES);
  localparam int unsigned MAX_GLYPH_BYTES = 64;
  localparam int unsigned CNT_W           = $clog2(MAX_GLYPH_BYTES);
  localparam logic [7:0]  STREAK_BYTE     = 8'h55;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_FIRST_CHAR,
    CFG_LAST_CHAR,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_idx_e;

  // Input operation kinds.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Control program.
  localparam int unsigned PC_W = 5;

  localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] PC_SIZE     = 5'd1;
  localparam logic [PC_W-1:0] PC_EMPTY    = 5'd2;
  localparam logic [PC_W-1:0] PC_TEST_MIS = 5'd3;
  localparam logic [PC_W-1:0] PC_TEST_MOD = 5'd4;
  localparam logic [PC_W-1:0] PC_B_ENTRY  = 5'd5;
  localparam logic [PC_W-1:0] PC_B_RDHI   = 5'd6;
  localparam logic [PC_W-1:0] PC_B_RDLO   = 5'd7;
  localparam logic [PC_W-1:0] PC_B_HI     = 5'd8;
  localparam logic [PC_W-1:0] PC_B_WORD   = 5'd9;
  localparam logic [PC_W-1:0] PC_B_DBASE  = 5'd10;
  localparam logic [PC_W-1:0] PC_B_BITS   = 5'd11;
  localparam logic [PC_W-1:0] PC_B_TEST   = 5'd12;
  localparam logic [PC_W-1:0] PC_B_ZERO   = 5'd13;
  localparam logic [PC_W-1:0] PC_B_DATA   = 5'd14;
  localparam logic [PC_W-1:0] PC_MISS     = 5'd15;
  localparam logic [PC_W-1:0] PC_P_BASE   = 5'd16;
  localparam logic [PC_W-1:0] PC_P_FIRST  = 5'd17;
  localparam logic [PC_W-1:0] PC_P_EMIT   = 5'd18;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_MISS,
    EM_ZERO,
    EM_RDATA
  } emit_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_BITS
  } rd_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SIZE,
    ACT_BASE,
    ACT_ENTRY,
    ACT_HI,
    ACT_WORD,
    ACT_DBASE,
    ACT_INC
  } act_e;

  typedef enum logic [2:0] {
    BR_ACCEPT,
    BR_NEXT,
    BR_GOTO,
    BR_EMPTY,
    BR_MISS,
    BR_MODE0,
    BR_BITSET,
    BR_LOOP
  } br_e;

  typedef struct packed {
    emit_e           emit;
    rd_e             rd;
    act_e            act;
    br_e             br;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t uc_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w.emit   = EM_NONE;
    w.rd     = RD_NONE;
    w.act    = ACT_NONE;
    w.br     = BR_NEXT;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.br = BR_ACCEPT; w.target = PC_SIZE;
      end
      PC_SIZE: begin
        w.act = ACT_SIZE;
      end
      PC_EMPTY: begin
        w.br = BR_EMPTY; w.target = PC_IDLE;
      end
      PC_TEST_MIS: begin
        w.br = BR_MISS; w.target = PC_MISS;
      end
      PC_TEST_MOD: begin
        w.br = BR_MODE0; w.target = PC_P_BASE;
      end
      PC_B_ENTRY: begin
        w.act = ACT_ENTRY;
      end
      PC_B_RDHI: begin
        w.rd = RD_PTR; w.act = ACT_INC;
      end
      PC_B_RDLO: begin
        // The high byte of the entry is on the read port during this step.
        w.rd = RD_PTR; w.act = ACT_HI;
      end
      PC_B_HI: begin
        w.act = ACT_NONE;
      end
      PC_B_WORD: begin
        w.act = ACT_WORD;
      end
      PC_B_DBASE: begin
        w.act = ACT_DBASE;
      end
      PC_B_BITS: begin
        w.rd = RD_BITS;
      end
      PC_B_TEST: begin
        w.rd = RD_PTR; w.br = BR_BITSET; w.target = PC_B_DATA;
      end
      PC_B_ZERO: begin
        w.emit = EM_ZERO; w.rd = RD_BITS; w.br = BR_LOOP; w.target = PC_B_TEST;
      end
      PC_B_DATA: begin
        w.emit = EM_RDATA; w.rd = RD_BITS; w.act = ACT_INC;
        w.br = BR_LOOP; w.target = PC_B_TEST;
      end
      PC_MISS: begin
        w.emit = EM_MISS; w.br = BR_LOOP; w.target = PC_MISS;
      end
      PC_P_BASE: begin
        w.act = ACT_BASE;
      end
      PC_P_FIRST: begin
        w.rd = RD_PTR; w.act = ACT_INC;
      end
      PC_P_EMIT: begin
        w.emit = EM_RDATA; w.rd = RD_PTR; w.act = ACT_INC;
        w.br = BR_LOOP; w.target = PC_P_EMIT;
      end
      default: begin
        w.br = BR_GOTO; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/fgb_ram.sv @@
`timescale 1ns / 1ps

module fgb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/font_glyph_bitset_decoder.sv @@
`timescale 1ns / 1ps

// Font glyph decoder. The slave stream takes items of two kinds (tuser):
// a load writes one byte into the 32 KiB font memory and leaves the program idle;
// a render streams the glyph's column bytes out of the master stream,
// with tlast on the final byte and tuser set when the glyph is missing.
// The configuration channel (always ready) sets mode, character range and
// glyph size; write it only while no render is in progress.
// A small control program steps through one glyph at a time, so the next
// item is accepted once the previous render has issued its last byte.
// Bytes follow at one per cycle for missing and plain glyphs while the
// receiver is ready, and more slowly for bitset glyphs, since the single
// font memory port reads bitset and data in turn. A stalled receiver
// holds the output register and the program simply waits. Reset
// restores the default configuration; font memory contents stay
// undefined until loaded.
module font_glyph_bitset_decoder
  import fgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // address[14:0], data[22:15], char_code[30:23]
  input  logic        s_axis_tuser,  // op
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // glyph_byte[7:0]
  output logic        m_axis_tuser,  // missing_glyph
  output logic        m_axis_tlast,  // last
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // Configuration registers.
  logic [1:0] mode_q;
  logic [7:0] first_q;
  logic [7:0] last_q;
  logic [5:0] width_q;
  logic [4:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd0;
      first_q  <= 8'd32;
      last_q   <= 8'd127;
      width_q  <= 6'd5;
      height_q <= 5'd8;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:       mode_q   <= cfg_data_i[1:0];
        CFG_FIRST_CHAR: first_q  <= cfg_data_i;
        CFG_LAST_CHAR:  last_q   <= cfg_data_i;
        CFG_WIDTH:      width_q  <= cfg_data_i[5:0];
        CFG_HEIGHT:     height_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [FONT_AW-1:0] in_addr;
  logic [7:0]         in_data;
  logic [7:0]         in_char;

  assign in_addr = FONT_AW'(s_axis_tdata[14:0]);
  assign in_data = s_axis_tdata[22:15];
  assign in_char = s_axis_tdata[30:23];

  // Sequencer and datapath state.
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]         chr_q;
  logic [7:0]         size_q;
  logic               miss_q;
  logic               esc_q;
  logic [7:0]         hi_q;
  logic [FONT_AW-1:0] bitset_q;
  logic [FONT_AW-1:0] ptr_q, ptr_d;

  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_miss_q;
  logic               out_last_q;

  ucode_t             uc;
  logic               out_free;
  logic               go;
  logic               accept;
  logic               emit_go;
  logic [7:0]         rdata;

  assign uc       = uc_rom(pc_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign accept   = (uc.br == BR_ACCEPT) && s_axis_tvalid;
  assign s_axis_tready = (uc.br == BR_ACCEPT);

  always_comb begin
    if (uc.br == BR_ACCEPT) begin
      go = s_axis_tvalid;
    end else if (uc.emit != EM_NONE) begin
      go = out_free;
    end else begin
      go = 1'b1;
    end
  end

  assign emit_go = go && (uc.emit != EM_NONE);

  // Glyph geometry.
  logic [5:0]       rows_sum;
  logic [8:0]       size_prod;
  logic [CNT_W:0]   count_w;
  logic             last_w;
  logic [8:0]       len_sum;
  logic [6:0]       len_w;
  logic [7:0]       diff;
  logic [15:0]      base_prod;
  logic             miss_w;

  assign rows_sum  = {1'b0, height_q} + 6'd7;
  assign size_prod = width_q * rows_sum[5:3];
  assign count_w   = (size_q > 8'(MAX_GLYPH_BYTES)) ? (CNT_W + 1)'(MAX_GLYPH_BYTES)
                                                    : size_q[CNT_W:0];
  assign last_w    = ((CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1)) == count_w;
  assign len_sum   = {1'b0, size_q} + 9'd7;
  assign len_w     = esc_q ? {len_sum[8:3], 1'b0} : {1'b0, len_sum[8:3]};
  assign diff      = chr_q - first_q;
  assign base_prod = diff * size_q;
  assign miss_w    = (chr_q < first_q) || (chr_q > last_q) || (mode_q > 2'd1);

  // Presence bit of the current byte, most significant bit first.
  logic [2:0] bit_idx;
  logic       bit_set;

  assign bit_idx = 3'd7 - cnt_q[2:0];
  assign bit_set = rdata[bit_idx];

  assign cnt_d = emit_go ? cnt_q + CNT_W'(1) : cnt_q;

  // Escaped bitsets use only their odd bytes.
  logic [CNT_W-3:0]   bits_idx;
  logic [FONT_AW-1:0] bits_off;
  logic [FONT_AW-1:0] bits_addr;

  assign bits_idx  = cnt_d[CNT_W-1:3];
  assign bits_off  = esc_q ? FONT_AW'({bits_idx, 1'b1}) : FONT_AW'(bits_idx);
  assign bits_addr = bitset_q + bits_off;

  // Font memory port.
  logic               ram_we;
  logic               ram_re;
  logic [FONT_AW-1:0] ram_addr;

  assign ram_we = accept && (s_axis_tuser == OP_LOAD);
  assign ram_re = go && (uc.rd != RD_NONE);

  always_comb begin
    case (uc.rd)
      RD_PTR:  ram_addr = ptr_q;
      RD_BITS: ram_addr = bits_addr;
      default: ram_addr = in_addr;
    endcase
  end

  fgb_ram #(
    .Width (8),
    .Depth (FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_data),
    .rdata_o (rdata)
  );

  // Next step.
  always_comb begin
    pc_d = pc_q;
    if (go) begin
      case (uc.br)
        BR_ACCEPT: pc_d = (s_axis_tuser == OP_RENDER) ? uc.target : pc_q;
        BR_NEXT:   pc_d = pc_q + PC_W'(1);
        BR_GOTO:   pc_d = uc.target;
        BR_EMPTY:  pc_d = (size_q == 8'd0) ? uc.target : pc_q + PC_W'(1);
        BR_MISS:   pc_d = miss_q ? uc.target : pc_q + PC_W'(1);
        BR_MODE0:  pc_d = (mode_q == 2'd0) ? uc.target : pc_q + PC_W'(1);
        BR_BITSET: pc_d = bit_set ? uc.target : pc_q + PC_W'(1);
        BR_LOOP:   pc_d = last_w ? PC_IDLE : uc.target;
        default:   pc_d = PC_IDLE;
      endcase
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (go) begin
      case (uc.act)
        ACT_BASE:  ptr_d = base_prod[FONT_AW-1:0];
        ACT_ENTRY: ptr_d = FONT_AW'({diff, 1'b0});
        ACT_DBASE: ptr_d = bitset_q + FONT_AW'(len_w);
        ACT_INC:   ptr_d = ptr_q + FONT_AW'(1);
        default:   ptr_d = ptr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= (go && (uc.act == ACT_SIZE)) ? '0 : cnt_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (accept) begin
      chr_q <= in_char;
    end
    if (go) begin
      case (uc.act)
        ACT_SIZE: begin
          size_q <= size_prod[7:0];
          miss_q <= miss_w;
        end
        ACT_HI: hi_q <= rdata;
        ACT_WORD: begin
          esc_q    <= hi_q[7];
          bitset_q <= FONT_AW'({hi_q[6:0], rdata});
        end
        default: ;
      endcase
    end
    if (emit_go) begin
      out_last_q <= last_w;
      case (uc.emit)
        EM_MISS: begin
          out_byte_q <= STREAK_BYTE;
          out_miss_q <= 1'b1;
        end
        EM_RDATA: begin
          out_byte_q <= rdata;
          out_miss_q <= 1'b0;
        end
        default: begin
          out_byte_q <= 8'd0;
          out_miss_q <= 1'b0;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_miss_q;
  assign m_axis_tlast  = out_last_q;

endmodule
